/* rtl/core/nec_ir_frame_decoder_core_assert.svh */
// ----------------------------------------------------------------------------
// NEC IR decoder assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_CORE_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define NIRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NIRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nirdc_pkg.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared widths, register indexes, phase codes and types.
// ----------------------------------------------------------------------------
package nirdc_pkg;

    localparam int TICK_W     = 16;
    localparam int CFG_W      = 16;
    localparam int NUM_CFG    = 8;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int FRAME_BITS = 32;
    localparam int IDX_W      = $clog2(FRAME_BITS);
    localparam int IN_DW      = 16;
    localparam int OUT_DW     = 24;

    localparam logic [2:0] REG_LEAD_MIN   = 3'd0;
    localparam logic [2:0] REG_LEAD_MAX   = 3'd1;
    localparam logic [2:0] REG_REPEAT_MIN = 3'd2;
    localparam logic [2:0] REG_REPEAT_MAX = 3'd3;
    localparam logic [2:0] REG_ZERO_MIN   = 3'd4;
    localparam logic [2:0] REG_ZERO_MAX   = 3'd5;
    localparam logic [2:0] REG_ONE_MIN    = 3'd6;
    localparam logic [2:0] REG_ONE_MAX    = 3'd7;

    localparam logic [CFG_W-1:0] RST_LEAD_MIN   = 16'd11981;
    localparam logic [CFG_W-1:0] RST_LEAD_MAX   = 16'd12902;
    localparam logic [CFG_W-1:0] RST_REPEAT_MIN = 16'd9907;
    localparam logic [CFG_W-1:0] RST_REPEAT_MAX = 16'd10829;
    localparam logic [CFG_W-1:0] RST_ZERO_MIN   = 16'd571;
    localparam logic [CFG_W-1:0] RST_ZERO_MAX   = 16'd1493;
    localparam logic [CFG_W-1:0] RST_ONE_MIN    = 16'd1613;
    localparam logic [CFG_W-1:0] RST_ONE_MAX    = 16'd2535;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] lead_min;
        logic [CFG_W-1:0] lead_max;
        logic [CFG_W-1:0] repeat_min;
        logic [CFG_W-1:0] repeat_max;
        logic [CFG_W-1:0] zero_min;
        logic [CFG_W-1:0] zero_max;
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] one_max;
    } cfg_bank_t;

    typedef struct packed {
        logic lead;
        logic rpt;
        logic zero;
        logic one;
    } edge_class_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] command;
        logic [7:0] address;
        logic       repeat_seen;
        logic       frame_valid;
    } result_t;

endpackage

/* rtl/core/nec_ir_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder core
// Decodes NEC remote frames from falling-edge interval words.
// ----------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  s_*       in    tvalid/tready     tdata[15:0]  edge_ticks
//  m_*       out   tvalid/tready     tdata[23:0]  one result per edge
//  apb       in    psel/penable      eight 16-bit window bounds at 4*i
//
//  One edge per cycle sustained while m_tready is high; an edge reaches m_*
//  through the class queue and then the result register after the phase
//  machine.
//  aresetn is synchronous: phase idle, windows at defaults, queue empty.
//  A two-entry class queue lets the edge side run while m_tready is low.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nirdc_pkg::IN_DW-1:0]       s_tdata,   // [15:0] edge_ticks
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] frame_valid, [1] repeat_seen, [9:2] address, [17:10] command,
    // [19:18] phase, [23:20] zero
    output logic [nirdc_pkg::OUT_DW-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nirdc_pkg::APB_AW-1:0]      paddr,
    input  logic [nirdc_pkg::APB_DW-1:0]      pwdata,
    output logic [nirdc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    nirdc_pkg::cfg_bank_t   cfg;
    nirdc_pkg::edge_class_t cls;
    nirdc_pkg::edge_class_t q_data;
    logic                   q_valid;
    logic                   q_ready;

    nirdc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nirdc_classify u_front (
        .edge_ticks (s_tdata),
        .cfg        (cfg),
        .cls        (cls)
    );

    nirdc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    nirdc_exec u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/core/nirdc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder window registers
// APB register bank holding the eight tick window bounds.
// ----------------------------------------------------------------------------
module nirdc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nirdc_pkg::APB_AW-1:0]        paddr,
    input  logic [nirdc_pkg::APB_DW-1:0]        pwdata,
    output logic [nirdc_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    output nirdc_pkg::cfg_bank_t                cfg
);

    nirdc_pkg::cfg_bank_t cfg_reg;
    logic [2:0]           reg_idx;
    logic                 wr_en;
    logic [nirdc_pkg::CFG_W-1:0] wdata;
    logic [nirdc_pkg::CFG_W-1:0] rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wdata   = pwdata[nirdc_pkg::CFG_W-1:0];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lead_min   <= nirdc_pkg::RST_LEAD_MIN;
            cfg_reg.lead_max   <= nirdc_pkg::RST_LEAD_MAX;
            cfg_reg.repeat_min <= nirdc_pkg::RST_REPEAT_MIN;
            cfg_reg.repeat_max <= nirdc_pkg::RST_REPEAT_MAX;
            cfg_reg.zero_min   <= nirdc_pkg::RST_ZERO_MIN;
            cfg_reg.zero_max   <= nirdc_pkg::RST_ZERO_MAX;
            cfg_reg.one_min    <= nirdc_pkg::RST_ONE_MIN;
            cfg_reg.one_max    <= nirdc_pkg::RST_ONE_MAX;
        end else if (wr_en) begin
            unique case (reg_idx)
                nirdc_pkg::REG_LEAD_MIN:   cfg_reg.lead_min   <= wdata;
                nirdc_pkg::REG_LEAD_MAX:   cfg_reg.lead_max   <= wdata;
                nirdc_pkg::REG_REPEAT_MIN: cfg_reg.repeat_min <= wdata;
                nirdc_pkg::REG_REPEAT_MAX: cfg_reg.repeat_max <= wdata;
                nirdc_pkg::REG_ZERO_MIN:   cfg_reg.zero_min   <= wdata;
                nirdc_pkg::REG_ZERO_MAX:   cfg_reg.zero_max   <= wdata;
                nirdc_pkg::REG_ONE_MIN:    cfg_reg.one_min    <= wdata;
                nirdc_pkg::REG_ONE_MAX:    cfg_reg.one_max    <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            nirdc_pkg::REG_LEAD_MIN:   rdata = cfg_reg.lead_min;
            nirdc_pkg::REG_LEAD_MAX:   rdata = cfg_reg.lead_max;
            nirdc_pkg::REG_REPEAT_MIN: rdata = cfg_reg.repeat_min;
            nirdc_pkg::REG_REPEAT_MAX: rdata = cfg_reg.repeat_max;
            nirdc_pkg::REG_ZERO_MIN:   rdata = cfg_reg.zero_min;
            nirdc_pkg::REG_ZERO_MAX:   rdata = cfg_reg.zero_max;
            nirdc_pkg::REG_ONE_MIN:    rdata = cfg_reg.one_min;
            nirdc_pkg::REG_ONE_MAX:    rdata = cfg_reg.one_max;
            default:                   rdata = '0;
        endcase
    end

    assign prdata = {{(nirdc_pkg::APB_DW - nirdc_pkg::CFG_W){1'b0}}, rdata};

endmodule

/* rtl/core/nirdc_classify.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder edge classifier
// Tests an edge interval against the four exclusive tick windows.
// ----------------------------------------------------------------------------
module nirdc_classify (
    input  logic [nirdc_pkg::IN_DW-1:0] edge_ticks,
    input  nirdc_pkg::cfg_bank_t        cfg,
    output nirdc_pkg::edge_class_t      cls
);

    logic [nirdc_pkg::TICK_W-1:0] ticks;

    assign ticks = edge_ticks[nirdc_pkg::TICK_W-1:0];

    assign cls.lead = (ticks > cfg.lead_min)   && (ticks < cfg.lead_max);
    assign cls.rpt  = (ticks > cfg.repeat_min) && (ticks < cfg.repeat_max);
    assign cls.zero = (ticks > cfg.zero_min)   && (ticks < cfg.zero_max);
    assign cls.one  = (ticks > cfg.one_min)    && (ticks < cfg.one_max);

endmodule

/* rtl/core/nirdc_queue.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder class queue
// Two-entry queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module nirdc_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  nirdc_pkg::edge_class_t push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output nirdc_pkg::edge_class_t pop_data
);

    nirdc_pkg::edge_class_t slot_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/nirdc_exec.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder frame engine
// Runs the phase machine, assembles the frame and registers the result word.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_core_assert.svh"

module nirdc_exec (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  nirdc_pkg::edge_class_t         q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nirdc_pkg::OUT_DW-1:0]   m_tdata
);

    logic [1:0]                    phase_reg,  phase_next;
    logic [nirdc_pkg::IDX_W-1:0]   idx_reg,    idx_next;
    logic [nirdc_pkg::FRAME_BITS-1:0] bits_reg, bits_next;
    logic [7:0]                    addr_reg,   addr_next;
    logic [7:0]                    cmd_reg,    cmd_next;
    logic                          frame_ok;
    logic                          rpt;
    logic                          out_vld_reg;
    nirdc_pkg::result_t            out_reg;
    nirdc_pkg::result_t            res;
    logic                          step;

    assign q_ready = !out_vld_reg || m_tready;
    assign step    = q_valid && q_ready;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        frame_ok   = 1'b0;
        rpt        = 1'b0;
        unique case (phase_reg)
            nirdc_pkg::PH_LEAD: begin
                if (q_data.lead) begin
                    phase_next = nirdc_pkg::PH_DATA;
                end else if (q_data.rpt) begin
                    rpt        = 1'b1;
                    phase_next = nirdc_pkg::PH_IDLE;
                end
            end
            nirdc_pkg::PH_DATA: begin
                if (q_data.zero || q_data.one) begin
                    bits_next[idx_reg] = !q_data.zero;
                    if (idx_reg == nirdc_pkg::IDX_W'(nirdc_pkg::FRAME_BITS - 1)) begin
                        idx_next   = '0;
                        phase_next = nirdc_pkg::PH_IDLE;
                        if ((bits_next[7:0] == ~bits_next[15:8]) &&
                            (bits_next[23:16] == ~bits_next[31:24])) begin
                            frame_ok  = 1'b1;
                            addr_next = bits_next[7:0];
                            cmd_next  = bits_next[23:16];
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    idx_next   = '0;
                    phase_next = nirdc_pkg::PH_LEAD;
                end
            end
            default: begin
                phase_next = nirdc_pkg::PH_LEAD;
            end
        endcase
    end

    assign res.frame_valid = frame_ok;
    assign res.repeat_seen = rpt;
    assign res.address     = addr_next;
    assign res.command     = cmd_next;
    assign res.phase       = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= nirdc_pkg::PH_IDLE;
            idx_reg     <= '0;
            addr_reg    <= 8'd0;
            cmd_reg     <= 8'd0;
            out_vld_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                addr_reg    <= addr_next;
                cmd_reg     <= cmd_next;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            bits_reg <= bits_next;
            out_reg  <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(nirdc_pkg::OUT_DW - $bits(nirdc_pkg::result_t)){1'b0}}, out_reg};

    `NIRD_ASSERT_IMP(a_pulse_excl, out_vld_reg, !(out_reg.frame_valid && out_reg.repeat_seen), "frame and repeat pulses together")
    `NIRD_ASSERT_IMP(a_frame_idle, out_vld_reg && out_reg.frame_valid, out_reg.phase == nirdc_pkg::PH_IDLE, "frame pulse outside idle")
    `NIRD_ASSERT_IMP(a_rpt_idle, out_vld_reg && out_reg.repeat_seen, out_reg.phase == nirdc_pkg::PH_IDLE, "repeat pulse outside idle")
    `NIRD_ASSERT_IMP(a_idx_data, idx_reg != '0, phase_reg == nirdc_pkg::PH_DATA, "bit index set outside data phase")
    `NIRD_ASSERT_NXT(a_step_out, step, out_vld_reg, "accepted edge left no result")

endmodule
